### design/rfd_pkg.sv
// Package for the RGB565 run-length frame decoder.
// Holds status codes, register indexes, opcodes and the channel scaler.
// Depends on nothing.
package rfd_pkg;

  localparam int unsigned PixCountBits = 20;

  localparam int unsigned FieldPixW = 20;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned StatusW   = 3;

  localparam logic [7:0]           BrightnessReset = 8'd255;
  localparam logic [CfgDataW-1:0]  PixelsReset     = 20'd256;

  localparam logic [CfgIndexW-1:0] RegBrightness = 1'b0;
  localparam logic [CfgIndexW-1:0] RegPixels     = 1'b1;

  localparam logic [StatusW-1:0] StatusOk        = 3'd0;
  localparam logic [StatusW-1:0] StatusTruncated = 3'd1;
  localparam logic [StatusW-1:0] StatusOverflow  = 3'd2;
  localparam logic [StatusW-1:0] StatusSkipKey   = 3'd3;
  localparam logic [StatusW-1:0] StatusBadOp     = 3'd4;

  localparam logic [7:0] OpLiteral = 8'd0;
  localparam logic [7:0] OpSkip    = 8'd1;
  localparam logic [7:0] OpFill    = 8'd2;

  // (v * b + 127) / 255, exact over the whole 8 by 8 bit range
  function automatic logic [7:0] scale_channel(input logic [7:0] v, input logic [7:0] b);
    logic [16:0] x;
    logic [16:0] q;
    x = 17'(v) * 17'(b) + 17'd127;
    q = (x + 17'd1 + (x >> 8)) >> 8;
    return q[7:0];
  endfunction

endpackage

### design/rgb565_run_frame_decoder.sv
// RGB565 run-length frame decoder: one record byte in, at most one run result out.
// Parses runs, tracks coverage and errors, widens and scales colours.
// Depends on rfd_pkg.
// An accepted byte's result passes the s1 register, then the output register.
// Throughput: one byte per cycle, unless in_stall_o is raised by a full pipeline.
// Reset clears the parse state, the pipeline valid bits, and sets brightness to 255
// and pixels_in_frame to 256.
module rgb565_run_frame_decoder #(
  parameter int unsigned PIXEL_COUNT_BITS = rfd_pkg::PixCountBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rfd_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [rfd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            is_keyframe_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rfd_pkg::FieldPixW-1:0]   pixel_index_o,
  output logic [15:0]                     run_length_o,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic                            frame_done_o,
  output logic [rfd_pkg::StatusW-1:0]     status_o
);
  import rfd_pkg::*;

  localparam int unsigned PixW = PIXEL_COUNT_BITS;
  localparam int unsigned SumW = PixW + 17;

  localparam logic [2:0] PhOpcode   = 3'd0;
  localparam logic [2:0] PhCountHi  = 3'd1;
  localparam logic [2:0] PhCountLo  = 3'd2;
  localparam logic [2:0] PhColourHi = 3'd3;
  localparam logic [2:0] PhColourLo = 3'd4;

  logic [7:0]         brightness_q;
  logic [PixW-1:0]    pixels_in_frame_q;
  logic [2:0]         phase_q, phase_d;
  logic [7:0]         opcode_q, opcode_d;
  logic [15:0]        remaining_q, remaining_d;
  logic [PixW-1:0]    produced_q, produced_d;
  logic [7:0]         colour_hi_q, colour_hi_d;
  logic [StatusW-1:0] err_q, err_d;

  logic                 s1_valid_q;
  logic [FieldPixW-1:0] s1_index_q;
  logic [15:0]          s1_len_q;
  logic [15:0]          s1_word_q;
  logic                 s1_done_q;
  logic [StatusW-1:0]   s1_status_q;

  logic                 out_valid_q;
  logic [FieldPixW-1:0] out_index_q;
  logic [15:0]          out_len_q;
  logic [7:0]           out_red_q, out_green_q, out_blue_q;
  logic                 out_done_q;
  logic [StatusW-1:0]   out_status_q;

  logic s2_adv, s1_adv, in_acc;

  logic [PixW+19:0] cfg_wide;
  logic [PixW+19:0] idx_wide;

  logic                 emit;
  logic                 present;
  logic [PixW-1:0]      idx;
  logic [15:0]          len;
  logic [15:0]          word;
  logic [StatusW-1:0]   err;
  logic [StatusW-1:0]   err_new;
  logic [15:0]          cnt;
  logic                 overflow;
  logic [SumW-1:0]      sum_ext;
  logic [FieldPixW-1:0] idx_field;

  assign s2_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && s1_adv;

  assign cfg_wide = {{PixW{1'b0}}, cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q      <= BrightnessReset;
      pixels_in_frame_q <= PixW'(PixelsReset);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBrightness: brightness_q      <= cfg_data_i[7:0];
        RegPixels:     pixels_in_frame_q <= cfg_wide[PixW-1:0];
        default: ;
      endcase
    end
  end

  assign cnt     = {remaining_q[15:8], data_byte_i};
  assign sum_ext = SumW'(produced_q) + SumW'(cnt);
  assign overflow = (cnt == 16'd0) || (sum_ext > SumW'(pixels_in_frame_q));

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    remaining_d = remaining_q;
    produced_d  = produced_q;
    colour_hi_d = colour_hi_q;
    err         = StatusOk;
    emit        = 1'b0;
    idx         = produced_q;
    len         = 16'd0;
    word        = {colour_hi_q, data_byte_i};
    if (err_q == StatusOk) begin
      case (phase_q)
        PhCountHi: begin
          remaining_d = {data_byte_i, 8'd0};
          phase_d     = PhCountLo;
          if (last_byte_i) err = StatusTruncated;
        end
        PhCountLo: begin
          if (overflow) begin
            err = StatusOverflow;
          end else if (opcode_q == OpSkip && is_keyframe_i) begin
            err = StatusSkipKey;
          end else if (opcode_q > OpFill) begin
            err = StatusBadOp;
          end else if (opcode_q == OpSkip) begin
            produced_d  = sum_ext[PixW-1:0];
            remaining_d = 16'd0;
            phase_d     = PhOpcode;
          end else begin
            remaining_d = cnt;
            phase_d     = PhColourHi;
            if (last_byte_i) err = StatusTruncated;
          end
        end
        PhColourHi: begin
          colour_hi_d = data_byte_i;
          phase_d     = PhColourLo;
          if (last_byte_i) err = StatusTruncated;
        end
        PhColourLo: begin
          emit = 1'b1;
          if (opcode_q == OpLiteral) begin
            len         = 16'd1;
            produced_d  = produced_q + PixW'(1);
            remaining_d = remaining_q - 16'd1;
            phase_d     = (remaining_d != 16'd0) ? PhColourHi : PhOpcode;
          end else begin
            len         = remaining_q;
            produced_d  = produced_q + PixW'(remaining_q);
            remaining_d = 16'd0;
            phase_d     = PhOpcode;
          end
          if (last_byte_i && phase_d != PhOpcode) err = StatusTruncated;
        end
        default: begin
          opcode_d = data_byte_i;
          phase_d  = PhCountHi;
          if (last_byte_i) err = StatusTruncated;
        end
      endcase
      if (last_byte_i && err == StatusOk && phase_d == PhOpcode &&
          produced_d != pixels_in_frame_q) begin
        err = StatusOverflow;
      end
    end
    err_new = (err_q == StatusOk) ? err : err_q;
    err_d   = err_new;
    if (err_new != StatusOk) emit = 1'b0;
    present = emit || last_byte_i;
    if (last_byte_i) begin
      phase_d     = PhOpcode;
      opcode_d    = 8'd0;
      remaining_d = 16'd0;
      produced_d  = '0;
      colour_hi_d = 8'd0;
      err_d       = StatusOk;
    end
  end

  assign idx_wide  = {20'd0, idx};
  assign idx_field = idx_wide[FieldPixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhOpcode;
      opcode_q    <= 8'd0;
      remaining_q <= 16'd0;
      produced_q  <= '0;
      colour_hi_q <= 8'd0;
      err_q       <= StatusOk;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      remaining_q <= remaining_d;
      produced_q  <= produced_d;
      colour_hi_q <= colour_hi_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_acc && present;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_index_q  <= emit ? idx_field : '0;
      s1_len_q    <= emit ? len : 16'd0;
      s1_word_q   <= emit ? word : 16'd0;
      s1_done_q   <= last_byte_i;
      s1_status_q <= last_byte_i ? err_new : StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_index_q  <= s1_index_q;
      out_len_q    <= s1_len_q;
      out_red_q    <= scale_channel({s1_word_q[15:11], s1_word_q[15:13]}, brightness_q);
      out_green_q  <= scale_channel({s1_word_q[10:5], s1_word_q[10:9]}, brightness_q);
      out_blue_q   <= scale_channel({s1_word_q[4:0], s1_word_q[4:2]}, brightness_q);
      out_done_q   <= s1_done_q;
      out_status_q <= s1_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_index_q;
  assign run_length_o  = out_len_q;
  assign red_o         = out_red_q;
  assign green_o       = out_green_q;
  assign blue_o        = out_blue_q;
  assign frame_done_o  = out_done_q;
  assign status_o      = out_status_q;

  a_mid_record_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_done_q |-> s1_status_q == StatusOk && s1_len_q != 16'd0)
    else $error("mid-record result without pixels or with status");

  a_record_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> phase_q == PhOpcode && err_q == StatusOk &&
      produced_q == '0)
    else $error("record state not cleared after last byte");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> s1_valid_q && s1_done_q)
    else $error("last byte gave no result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free pipeline room");

  a_error_blocks_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && err_q != StatusOk |=> !s1_valid_q || s1_done_q)
    else $error("pixel emitted after a latched error");

endmodule
